[sv/lge_pkg.sv]
// ----------------------------------------------------------------------------
// lge_pkg: shared types and constants of the life generation engine
// Request and result structs, command codes, register indexes, rule counts.
// ----------------------------------------------------------------------------
package lge_pkg;

  localparam int OPCODE_W    = 2;
  localparam int COORD_W     = 7;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [OPCODE_W-1:0] OP_SET   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RUN   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_SIDE_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_GENS_PER_RUN = 1'b1;

  localparam logic [7:0]  SIDE_LENGTH_RESET = 8'd100;
  localparam logic [15:0] GENS_PER_RUN_RESET = 16'd1;

  // B3/S23
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] KEEP_COUNT  = 4'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  column;
  } lge_request_t;

  typedef struct packed {
    logic        cell_alive;
    logic [31:0] total_generations;
    logic        bad_coordinate;
  } lge_result_t;

endpackage

[sv/lge_ram.sv]
// ----------------------------------------------------------------------------
// lge_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lge_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/lge_row_eval.sv]
// ----------------------------------------------------------------------------
// lge_row_eval: next state of one grid row
// Counts the eight neighbours of every cell from three masked rows and
// applies the birth/survival rule; cells outside the live area come out dead.
// ----------------------------------------------------------------------------
module lge_row_eval #(
  parameter int WIDTH = 128
) (
  input  logic [WIDTH-1:0] up,
  input  logic [WIDTH-1:0] mid,
  input  logic [WIDTH-1:0] down,
  input  logic [WIDTH-1:0] col_mask,
  output logic [WIDTH-1:0] next_row
);
  import lge_pkg::*;

  logic [WIDTH+1:0] up_x, mid_x, down_x;

  assign up_x   = {1'b0, up, 1'b0};
  assign mid_x  = {1'b0, mid, 1'b0};
  assign down_x = {1'b0, down, 1'b0};

  always_comb begin
    logic [3:0] cnt;
    cnt = '0;
    for (int i = 0; i < WIDTH; i++) begin
      // padded index i+1 is the cell itself
      cnt = 4'(up_x[i]) + 4'(up_x[i+1]) + 4'(up_x[i+2])
          + 4'(mid_x[i]) + 4'(mid_x[i+2])
          + 4'(down_x[i]) + 4'(down_x[i+1]) + 4'(down_x[i+2]);
      next_row[i] = col_mask[i]
                  & ((cnt == BIRTH_COUNT) | ((cnt == KEEP_COUNT) & mid[i]));
    end
  end

endmodule

[sv/life_generation_engine.sv]
// ----------------------------------------------------------------------------
// life_generation_engine: B3/S23 cellular automaton on a square grid
// Grid rows live in two row-wide RAMs used ping-pong; a run sweeps one row
// read per cycle and writes the new row into the other bank.
// ----------------------------------------------------------------------------
// Set and read pass through ST_ACCESS before done is raised; a bad coordinate,
// a clear or a run with zero generations raises done without that state.
// Run rate is set by the single read port of the current-grid RAM: one row per
// cycle plus window fill/drain per generation. One request at a time.
// Reset: grid empty via per-row valid bits cleared at once (no clearing pass),
// side_length 100, generations_per_run 1, generation count 0.
module life_generation_engine #(
  parameter int MAX_SIDE    = 128,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  lge_pkg::lge_request_t            request,
  output logic                             done,
  output lge_pkg::lge_result_t             result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lge_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lge_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lge_pkg::*;

  localparam int AW   = $clog2(MAX_SIDE);
  localparam int SW   = $clog2(MAX_SIDE + 2);
  localparam int CMPW = (SW > 8) ? SW : 8;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ACCESS = 2'd1;
  localparam logic [1:0] ST_GEN    = 2'd2;

  // control
  logic [1:0]             state;
  logic                   bank;
  logic [7:0]             side_length;
  logic [15:0]            gens_per_run;
  logic [15:0]            gens_left;
  logic [COUNT_WIDTH-1:0] gen_count;
  logic [SW-1:0]          rd_cnt;
  logic                   ret_valid;
  logic [MAX_SIDE-1:0]    valid_bits [2];
  logic                   done_next;

  // payload
  logic [OPCODE_W-1:0]    op_q;
  logic [AW-1:0]          row_q;
  logic [AW-1:0]          col_q;
  logic [SW-1:0]          ret_row;
  logic                   ret_live;
  logic [MAX_SIDE-1:0]    up_r, mid_r, cmask_r;
  logic                   alive_q, bad_q;

  // datapath
  logic                   accept;
  logic [SW-1:0]          eff;
  logic                   req_bad;
  logic [AW-1:0]          req_row_idx, req_col_idx;
  logic                   rd_issue, rd_live;
  logic [MAX_SIDE-1:0]    ram_rdata [2];
  logic [AW-1:0]          ram_raddr;
  logic                   wr_en, wr_bank, wr_gen;
  logic [AW-1:0]          wr_addr;
  logic [MAX_SIDE-1:0]    wr_data;
  logic [SW-1:0]          gen_row;
  logic [MAX_SIDE-1:0]    cur_row, loaded, down_row, next_row, set_bit;
  logic                   gen_end;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;

  always_comb begin
    if (CMPW'(side_length) > CMPW'(MAX_SIDE)) begin
      eff = SW'(MAX_SIDE);
    end else begin
      eff = SW'(side_length);
    end
  end

  assign req_row_idx = AW'(request.row);
  assign req_col_idx = AW'(request.column);
  assign req_bad = (CMPW'(request.row) >= CMPW'(eff))
                || (CMPW'(request.column) >= CMPW'(eff));

  assign rd_issue = (state == ST_GEN) && (rd_cnt <= eff);
  assign rd_live  = rd_cnt < eff;
  assign ram_raddr = (state == ST_IDLE) ? req_row_idx : rd_cnt[AW-1:0];

  assign cur_row  = bank ? ram_rdata[1] : ram_rdata[0];
  assign loaded   = ret_live ? cur_row : '0;
  assign down_row = loaded & cmask_r;
  assign set_bit  = {{(MAX_SIDE-1){1'b0}}, 1'b1} << col_q;
  assign gen_row  = ret_row - SW'(1);

  assign wr_gen  = (state == ST_GEN) && ret_valid && (ret_row != '0);
  assign gen_end = (state == ST_GEN) && ret_valid && (ret_row == eff);

  always_comb begin
    wr_en   = 1'b0;
    wr_bank = bank;
    wr_addr = row_q;
    wr_data = loaded | set_bit;
    if ((state == ST_ACCESS) && (op_q == OP_SET)) begin
      wr_en = 1'b1;
    end else if (wr_gen) begin
      wr_en   = 1'b1;
      wr_bank = ~bank;
      wr_addr = gen_row[AW-1:0];
      wr_data = next_row;
    end
  end

  // result strobe: immediate answers, end of access, end of the last sweep
  always_comb begin
    done_next = 1'b0;
    if (accept) begin
      case (request.opcode)
        OP_SET, OP_READ: done_next = req_bad;
        OP_CLEAR:        done_next = 1'b1;
        OP_RUN:          done_next = (gens_per_run == '0);
        default:         done_next = 1'b1;
      endcase
    end else if (state == ST_ACCESS) begin
      done_next = 1'b1;
    end else if (gen_end && (gens_left == 16'd1)) begin
      done_next = 1'b1;
    end
  end

  for (genvar b = 0; b < 2; b++) begin : g_bank
    lge_ram #(
      .WIDTH (MAX_SIDE),
      .DEPTH (MAX_SIDE)
    ) u_ram (
      .clk   (clk),
      .we    (wr_en && (wr_bank == 1'(b))),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (ram_raddr),
      .rdata (ram_rdata[b])
    );
  end

  // window: up_r = row k-2, mid_r = row k-1, down_row = row k just returned
  lge_row_eval #(
    .WIDTH (MAX_SIDE)
  ) u_row_eval (
    .up       (up_r),
    .mid      (mid_r),
    .down     (down_row),
    .col_mask (cmask_r),
    .next_row (next_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      bank          <= 1'b0;
      side_length   <= SIDE_LENGTH_RESET;
      gens_per_run  <= GENS_PER_RUN_RESET;
      gens_left     <= '0;
      gen_count     <= '0;
      rd_cnt        <= '0;
      ret_valid     <= 1'b0;
      done          <= 1'b0;
      valid_bits[0] <= '0;
      valid_bits[1] <= '0;
    end else begin
      done <= done_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SIDE_LENGTH:  side_length  <= cfg_data[7:0];
          REG_GENS_PER_RUN: gens_per_run <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (request.opcode)
              OP_SET, OP_READ: begin
                if (!req_bad) begin
                  state <= ST_ACCESS;
                end
              end
              OP_CLEAR: begin
                valid_bits[bank] <= '0;
              end
              OP_RUN: begin
                if (gens_per_run != '0) begin
                  state             <= ST_GEN;
                  gens_left         <= gens_per_run;
                  rd_cnt            <= '0;
                  ret_valid         <= 1'b0;
                  valid_bits[~bank] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_ACCESS: begin
          if (op_q == OP_SET) begin
            valid_bits[bank][row_q] <= 1'b1;
          end
          state <= ST_IDLE;
        end
        ST_GEN: begin
          // no read is issued in the cycle that ends a sweep
          ret_valid <= rd_issue;
          if (rd_issue) begin
            rd_cnt <= rd_cnt + SW'(1);
          end
          if (wr_gen) begin
            valid_bits[~bank][gen_row[AW-1:0]] <= 1'b1;
          end
          if (gen_end) begin
            bank      <= ~bank;
            gen_count <= gen_count + COUNT_WIDTH'(1);
            gens_left <= gens_left - 16'd1;
            rd_cnt    <= '0;
            if (gens_left == 16'd1) begin
              state <= ST_IDLE;
            end else begin
              // old current bank becomes the target of the next sweep
              valid_bits[bank] <= '0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= request.opcode;
      row_q    <= req_row_idx;
      col_q    <= req_col_idx;
      ret_live <= valid_bits[bank][req_row_idx];
      alive_q  <= 1'b0;
      bad_q    <= ((request.opcode == OP_SET) || (request.opcode == OP_READ)) && req_bad;
      up_r     <= '0;
      mid_r    <= '0;
      for (int i = 0; i < MAX_SIDE; i++) begin
        cmask_r[i] <= eff > SW'(i);
      end
    end
    if (state == ST_ACCESS) begin
      alive_q <= (op_q == OP_READ) && loaded[col_q];
    end
    if (state == ST_GEN) begin
      ret_row  <= rd_cnt;
      ret_live <= rd_live && valid_bits[bank][rd_cnt[AW-1:0]];
      if (gen_end) begin
        up_r  <= '0;
        mid_r <= '0;
      end else if (ret_valid) begin
        up_r  <= mid_r;
        mid_r <= down_row;
      end
    end
  end

  always_comb begin
    result.cell_alive        = alive_q;
    result.total_generations = 32'(gen_count);
    result.bad_coordinate    = bad_q;
  end

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_IDLE))
    else $error("result strobe while engine still busy");

  a_gen_bank: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_GEN) && wr_en) |-> (wr_bank != bank))
    else $error("sweep writes into the bank it reads");

  a_count_run: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && ($past(state) != ST_GEN)) |-> $stable(gen_count))
    else $error("generation count moved outside a run");

  a_ret_row: assert property (@(posedge clk) disable iff (rst)
    ret_valid |-> (ret_row <= eff))
    else $error("returned row beyond live area");
`endif

endmodule
